/* design/ffua_pkg.sv */
// Package for the first-fit unit allocator: map size, derived widths,
// request and response beat types, controller states.
// Used by first_fit_unit_allocator; no dependencies.
package ffua_pkg;

  localparam int MAP_UNITS = 32;
  localparam int IDX_W     = $clog2(MAP_UNITS);
  localparam int CNT_W     = $clog2(MAP_UNITS + 1);
  localparam int ENTRY_W   = 9;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] process_id;
    logic [5:0] unit_count;
  } req_t;

  typedef struct packed {
    logic       success;
    logic [4:0] start_unit;
    logic [5:0] freed_count;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ASCAN,
    ST_AWRITE,
    ST_FSCAN,
    ST_DONE
  } state_t;

endpackage

/* design/ffua_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No package dependencies.
module ffua_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/first_fit_unit_allocator.sv */
// First-fit unit allocator: the owner map sits in one RAM that is scanned one
// unit per cycle through its single read port. An allocate beat scans up to
// the last unit of the first run that fits and then writes the run; an
// allocation that finds no run scans the whole map. A free beat scans up to
// the first miss after the freed run, or to the top unit when the run reaches
// it or the id owns nothing. Bad allocation lengths skip the scan. The next
// request can be taken in the cycle after the response is loaded, and a
// response held by a stall holds the controller. The map is free after reset
// with no clearing pass: a per-unit written flag masks never-written entries.
// One request is worked at a time; the response register holds a finished
// beat until it is taken.
// Depends on ffua_pkg and ffua_ram.
module first_fit_unit_allocator (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  ffua_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output ffua_pkg::rsp_t rsp
);
  import ffua_pkg::*;

  state_t state, state_next;

  logic [7:0]         id;
  logic [5:0]         count;
  logic [CNT_W-1:0]   issue;
  logic               pend;
  logic [IDX_W-1:0]   pidx;
  logic [CNT_W-1:0]   run;
  logic               found;
  logic [IDX_W-1:0]   start;
  logic [IDX_W-1:0]   last;
  logic [IDX_W-1:0]   waddr;
  logic [CNT_W-1:0]   nfree;
  logic               ok;
  logic [MAP_UNITS-1:0] written;
  logic               rd_mask;

  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic [ENTRY_W-1:0] rd_data;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ENTRY_W-1:0] wr_data;

  logic [ENTRY_W-1:0] entry;
  logic [ENTRY_W-1:0] want;
  logic               pidx_last;
  logic [CNT_W-1:0]   run_inc;
  logic               a_hit;
  logic               a_miss;
  logic               f_match;
  logic               f_end;
  logic               bad_len;
  logic               accept;
  logic               load_rsp;
  logic [IDX_W-1:0]   a_start;

  ffua_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAP_UNITS)
  ) u_map (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // never-written units read as free
  assign entry     = rd_mask ? rd_data : '0;
  assign want      = {1'b1, id};
  assign pidx_last = (pidx == IDX_W'(MAP_UNITS - 1));
  assign run_inc   = run + CNT_W'(1);
  assign a_hit     = pend && !entry[8] && (32'(run_inc) == 32'(count));
  assign a_miss    = pend && pidx_last && !a_hit;
  assign f_match   = pend && (entry == want);
  // free ends at the top of the map, on the first miss after the run, or
  // at the top with nothing found
  assign f_end     = pend && ((f_match && pidx_last) || (!f_match && (found || pidx_last)));
  assign a_start   = IDX_W'(32'(pidx) + 32'd1 - 32'(count));
  assign bad_len   = (req.unit_count == 6'd0) || (32'(req.unit_count) > 32'(MAP_UNITS));
  assign rd_addr   = issue[IDX_W-1:0];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          if (req.kind == KIND_FREE) begin
            state_next = ST_FSCAN;
          end else if (bad_len) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_ASCAN;
          end
        end
      end
      ST_ASCAN: begin
        if (a_hit) begin
          state_next = ST_AWRITE;
        end else if (a_miss) begin
          state_next = ST_DONE;
        end
      end
      ST_AWRITE: begin
        if (waddr == last) begin
          state_next = ST_DONE;
        end
      end
      ST_FSCAN: begin
        if (f_end) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the controller
  always_comb begin
    req_stall = 1'b1;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = waddr;
    wr_data   = want;
    load_rsp  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
      end
      ST_ASCAN: begin
        rd_en = (32'(issue) < 32'(MAP_UNITS));
      end
      ST_AWRITE: begin
        wr_en = 1'b1;
      end
      ST_FSCAN: begin
        rd_en   = (32'(issue) < 32'(MAP_UNITS));
        wr_en   = f_match;
        wr_addr = pidx;
        wr_data = '0;
      end
      ST_DONE: begin
        load_rsp = !rsp_valid || !rsp_stall;
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

  assign accept = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
      written   <= '0;
    end else begin
      state <= state_next;
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (state == ST_ASCAN || state == ST_FSCAN) begin
        pend <= rd_en && (state_next == state);
      end else begin
        pend <= 1'b0;
      end
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      id    <= req.process_id;
      count <= req.unit_count;
      issue <= '0;
      run   <= '0;
      found <= 1'b0;
      nfree <= '0;
      ok    <= 1'b0;
      start <= '0;
    end
    if (rd_en) begin
      issue   <= issue + CNT_W'(1);
      pidx    <= rd_addr;
      rd_mask <= written[rd_addr];
    end
    if (state == ST_ASCAN && pend) begin
      run <= entry[8] ? '0 : run_inc;
      if (a_hit) begin
        start <= a_start;
        waddr <= a_start;
        last  <= pidx;
        ok    <= 1'b1;
      end
    end
    if (state == ST_AWRITE) begin
      waddr <= waddr + IDX_W'(1);
    end
    if (state == ST_FSCAN && f_match) begin
      if (!found) begin
        start <= pidx;
      end
      found <= 1'b1;
      ok    <= 1'b1;
      nfree <= nfree + CNT_W'(1);
    end
    if (load_rsp) begin
      rsp.success     <= ok;
      rsp.start_unit  <= 5'(start);
      rsp.freed_count <= 6'(nfree);
    end
  end

endmodule

/* tb/ffua_checker.sv */
// Checker for the first-fit unit allocator: keeps its own copy of the owner
// map, predicts every response from the accepted request beats and compares.
// Depends on ffua_pkg.
module ffua_map_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_stall,
  input  ffua_pkg::req_t req,
  input  logic           rsp_valid,
  input  logic           rsp_stall,
  input  ffua_pkg::rsp_t rsp,
  output int             mismatches,
  output int             outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import ffua_pkg::*;

  typedef struct packed {
    logic       used;
    logic [7:0] owner;
  } unit_t;

  unit_t unit_map [MAP_UNITS];
  rsp_t  awaited_rsp [$];

  // Apply one request to the map and return the response it should produce.
  function automatic rsp_t resolve_request(req_t r);
    rsp_t res;
    int   run;
    int   first;
    int   i;
    int   j;
    bit   found;
    res   = '0;
    run   = 0;
    first = 0;
    found = 1'b0;
    if (r.kind == KIND_ALLOC) begin
      if (r.unit_count != 0 && r.unit_count <= MAP_UNITS) begin
        for (i = 0; i < MAP_UNITS; i++) begin
          if (!found) begin
            if (unit_map[IDX_W'(i)].used) begin
              run = 0;
            end else begin
              run++;
              if (run == r.unit_count) begin
                found = 1'b1;
                first = i + 1 - run;
              end
            end
          end
        end
        if (found) begin
          for (j = first; j < first + r.unit_count; j++) begin
            unit_map[IDX_W'(j)].used  = 1'b1;
            unit_map[IDX_W'(j)].owner = r.process_id;
          end
          res.success    = 1'b1;
          res.start_unit = first[4:0];
        end
      end
    end else begin
      for (i = 0; i < MAP_UNITS; i++) begin
        if (!found && unit_map[IDX_W'(i)].used &&
            unit_map[IDX_W'(i)].owner == r.process_id) begin
          found = 1'b1;
          first = i;
        end
      end
      if (found) begin
        // release only the first run; higher units of the same owner stay
        run = 0;
        j   = first;
        while (j < MAP_UNITS && unit_map[IDX_W'(j)].used &&
               unit_map[IDX_W'(j)].owner == r.process_id) begin
          unit_map[IDX_W'(j)] = '0;
          run++;
          j++;
        end
        res.success     = 1'b1;
        res.start_unit  = first[4:0];
        res.freed_count = run[5:0];
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    int   errs;
    errs = 0;
    if (rst) begin
      foreach (unit_map[k]) unit_map[k] = '0;
      awaited_rsp.delete();
    end else begin
      // take the response beat first: it belongs to an older request
      if (rsp_valid && !rsp_stall) begin
        if (awaited_rsp.size() == 0) begin
          $display("%0t: unexpected response beat, expected none, got %p", $time, rsp);
          errs++;
        end else begin
          want = awaited_rsp.pop_front();
          if (rsp.success !== want.success) begin
            $display("%0t: success expected %0d, got %0d", $time, want.success,
                     rsp.success);
            errs++;
          end
          if (rsp.start_unit !== want.start_unit) begin
            $display("%0t: start_unit expected %0d, got %0d", $time, want.start_unit,
                     rsp.start_unit);
            errs++;
          end
          if (rsp.freed_count !== want.freed_count) begin
            $display("%0t: freed_count expected %0d, got %0d", $time, want.freed_count,
                     rsp.freed_count);
            errs++;
          end
        end
      end
      if (req_valid && !req_stall) begin
        awaited_rsp.push_back(resolve_request(req));
      end
    end
    mismatches  <= mismatches + errs;
    outstanding <= awaited_rsp.size();
  end

endmodule

/* tb/tb_top.sv */
// Top of the allocator testbench: clock, reset, request stimulus with bursts
// and gaps, response stall pattern and the verdict.
// Depends on ffua_pkg, first_fit_unit_allocator and ffua_map_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ffua_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 1650;
  localparam int DRAIN_CYCLES = 2 * MAP_UNITS + 16;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;
  int   mismatches;
  int   outstanding;
  int   burst_left;
  int   stall_mode;
  int   stall_left;
  logic [7:0] id_pool [8];

  first_fit_unit_allocator u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  ffua_map_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Receiver stall: switch among no stall, light stall and heavy stall.
  always @(negedge clk) begin
    if (rst) begin
      rsp_stall  <= 1'b0;
      stall_mode = 0;
      stall_left = 0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      case (stall_mode)
        0: begin
          rsp_stall <= 1'b0;
        end
        1: begin
          rsp_stall <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          rsp_stall <= ($urandom_range(0, 3) != 0);
        end
      endcase
    end
  end

  function automatic req_t mk(logic kind, logic [7:0] id, logic [5:0] count);
    req_t r;
    r.kind       = kind;
    r.process_id = id;
    r.unit_count = count;
    return r;
  endfunction

  // Mostly owners from a small pool so frees find runs; some stray ids and
  // some bad lengths mixed in.
  function automatic req_t random_request();
    req_t r;
    int   pick;
    int   count;
    pick   = $urandom_range(0, 99);
    r.kind = (pick < 55) ? KIND_ALLOC : KIND_FREE;
    pick   = $urandom_range(0, 99);
    r.process_id = (pick < 65) ? id_pool[3'($urandom_range(0, 7))] :
                                 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 65) count = $urandom_range(1, 6);
    else if (pick < 85) count = $urandom_range(7, 16);
    else if (pick < 93) count = $urandom_range(17, 32);
    else if (pick < 96) count = 0;
    else count = $urandom_range(33, 63);
    r.unit_count = 6'(count);
    return r;
  endfunction

  // Drive one request beat; hold it until accepted, then return at the
  // following falling edge.
  task automatic send(input req_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 6);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    req       <= r;
    req_valid <= 1'b1;
    burst_left--;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    rst        = 1'b1;
    req_valid  = 1'b0;
    req        = '0;
    burst_left = 0;
    foreach (id_pool[k]) id_pool[k] = 8'($urandom_range(0, 255));
    id_pool[0] = 8'h00;
    id_pool[1] = 8'hFF;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // bad lengths
    send(mk(KIND_ALLOC, 8'h11, 6'd0));
    send(mk(KIND_ALLOC, 8'h11, 6'd63));
    send(mk(KIND_ALLOC, 8'h11, 6'd33));
    // fill the whole map, fail on a full map, free it all
    send(mk(KIND_ALLOC, 8'h00, 6'd32));
    send(mk(KIND_ALLOC, 8'h22, 6'd1));
    send(mk(KIND_FREE,  8'h00, 6'd0));
    send(mk(KIND_FREE,  8'h00, 6'h3F));
    // owner split in two runs; free takes only the lower one
    send(mk(KIND_ALLOC, 8'hFF, 6'd1));
    send(mk(KIND_ALLOC, 8'h07, 6'd3));
    send(mk(KIND_ALLOC, 8'hFF, 6'd2));
    send(mk(KIND_FREE,  8'hFF, 6'h3F));
    // first fit skips a hole that is too short, then fills it
    send(mk(KIND_ALLOC, 8'h2A, 6'd4));
    send(mk(KIND_ALLOC, 8'h2A, 6'd1));
    send(mk(KIND_FREE,  8'hFF, 6'd1));
    send(mk(KIND_ALLOC, 8'h55, 6'd2));
    send(mk(KIND_ALLOC, 8'h55, 6'd5));
    // two adjacent grants to one owner free as a single run up to the top
    send(mk(KIND_ALLOC, 8'hAA, 6'd3));
    send(mk(KIND_ALLOC, 8'hAA, 6'd14));
    send(mk(KIND_FREE,  8'hAA, 6'd0));
    send(mk(KIND_FREE,  8'h07, 6'd5));
    send(mk(KIND_ALLOC, 8'h80, 6'd32));
    send(mk(KIND_FREE,  8'h2A, 6'd0));
    send(mk(KIND_FREE,  8'h2A, 6'd0));
    send(mk(KIND_FREE,  8'h55, 6'd0));

    repeat (RANDOM_ITEMS) send(random_request());
    req_valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/ffua_pkg.sv
design/ffua_ram.sv
design/first_fit_unit_allocator.sv
tb/ffua_checker.sv
tb/tb_top.sv
